>>> sv/tgaisp_pkg.sv
// Shared types and constants of the TGA indexed stream parser.
package tgaisp_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int MAP_LEN_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int HDR_BYTES = 18;
    localparam int BCNT_W = $clog2(HDR_BYTES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] TGA_TYPE_INDEXED = 8'd1;
    localparam logic [7:0] TGA_MAP_PRESENT = 8'd1;
    localparam logic [7:0] TGA_PIXEL_BITS = 8'd8;
    localparam logic [7:0] TGA_MAP_BITS = 8'd24;
    localparam logic [7:0] TGA_TOP_ORIGIN = 8'h20;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_ERROR = 3'd1;
    localparam logic [2:0] KIND_PALETTE = 3'd2;
    localparam logic [2:0] KIND_FILL = 3'd3;
    localparam logic [2:0] KIND_PIXEL = 3'd4;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_TYPE = 3'd1;
    localparam logic [2:0] ERR_MAP_TYPE = 3'd2;
    localparam logic [2:0] ERR_PIXEL_BITS = 3'd3;
    localparam logic [2:0] ERR_MAP_BITS = 3'd4;
    localparam logic [2:0] ERR_DESCRIPTOR = 3'd5;
    localparam logic [2:0] ERR_SIZE = 3'd6;
    localparam logic [2:0] ERR_MAP_LENGTH = 3'd7;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_ID,
        PH_MAP,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic [2:0]           error_code;
        logic [15:0]          entry_or_x;
        logic [15:0]          pixel_row;
        logic [7:0]           value_or_red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic [15:0]          image_width;
        logic [15:0]          image_height;
        logic                 fill_after;
        logic [MAP_LEN_W-1:0] fill_start;
    } cmd_t;

endpackage

>>> sv/tgaisp_front.sv
// Front end: takes file bytes, tracks the parse phase and issues result commands.
module tgaisp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                start_file,
    input  logic                q_full,
    output logic                q_push,
    output tgaisp_pkg::cmd_t    q_cmd
);

    tgaisp_pkg::phase_t                   phase_reg, phase_next;
    logic [tgaisp_pkg::BCNT_W-1:0]        byte_count_reg, byte_count_next;
    logic [7:0]                           header_reg [tgaisp_pkg::HDR_BYTES];
    logic [7:0]                           id_left_reg, id_left_next;
    logic [tgaisp_pkg::MAP_LEN_W-1:0]     map_length_reg, map_length_next;
    logic [tgaisp_pkg::MAP_LEN_W-1:0]     map_index_reg, map_index_next;
    logic [15:0]                          triple_reg, triple_next;
    logic [1:0]                           triple_pos_reg, triple_pos_next;
    logic [15:0]                          column_reg, column_next;
    logic [15:0]                          row_reg, row_next;

    tgaisp_pkg::phase_t                   ph;
    logic [tgaisp_pkg::BCNT_W-1:0]        bc;
    logic                                 accept;
    logic [15:0]                          hw, hh, hlen, pw, ph_h;
    logic [2:0]                           code;
    logic [tgaisp_pkg::MAP_LEN_W-1:0]     idx_inc;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;
    assign ph = start_file ? tgaisp_pkg::PH_HEADER : phase_reg;
    assign bc = start_file ? '0 : byte_count_reg;
    assign hw = {header_reg[13], header_reg[12]};
    assign hh = {header_reg[15], header_reg[14]};
    assign hlen = {header_reg[6], header_reg[5]};
    assign pw = hw;
    assign ph_h = hh;
    assign idx_inc = map_index_reg + 1'b1;

    always_comb
    begin
        code = tgaisp_pkg::ERR_NONE;
        if (header_reg[2] != tgaisp_pkg::TGA_TYPE_INDEXED)
            code = tgaisp_pkg::ERR_TYPE;
        else if (header_reg[1] != tgaisp_pkg::TGA_MAP_PRESENT)
            code = tgaisp_pkg::ERR_MAP_TYPE;
        else if (header_reg[16] != tgaisp_pkg::TGA_PIXEL_BITS)
            code = tgaisp_pkg::ERR_PIXEL_BITS;
        else if (header_reg[7] != tgaisp_pkg::TGA_MAP_BITS)
            code = tgaisp_pkg::ERR_MAP_BITS;
        else if ((data_byte & ~tgaisp_pkg::TGA_TOP_ORIGIN) != 8'd0)
            code = tgaisp_pkg::ERR_DESCRIPTOR;
        else if (hw == 16'd0 || hh == 16'd0)
            code = tgaisp_pkg::ERR_SIZE;
        else if (hlen > 16'(tgaisp_pkg::PALETTE_ENTRIES))
            code = tgaisp_pkg::ERR_MAP_LENGTH;
    end

    always_comb
    begin
        phase_next = phase_reg;
        byte_count_next = byte_count_reg;
        id_left_next = id_left_reg;
        map_length_next = map_length_reg;
        map_index_next = map_index_reg;
        triple_next = triple_reg;
        triple_pos_next = triple_pos_reg;
        column_next = column_reg;
        row_next = row_reg;
        q_push = 1'b0;
        q_cmd = '0;
        if (accept)
        begin
            phase_next = ph;
            byte_count_next = bc;
            case (ph)
                tgaisp_pkg::PH_HEADER:
                begin
                    if (bc != tgaisp_pkg::BCNT_W'(tgaisp_pkg::HDR_BYTES - 1))
                    begin
                        byte_count_next = bc + 1'b1;
                    end
                    else
                    begin
                        byte_count_next = '0;
                        q_push = 1'b1;
                        if (code != tgaisp_pkg::ERR_NONE)
                        begin
                            q_cmd.kind = tgaisp_pkg::KIND_ERROR;
                            q_cmd.error_code = code;
                            phase_next = tgaisp_pkg::PH_ERROR;
                        end
                        else
                        begin
                            q_cmd.kind = tgaisp_pkg::KIND_HEADER;
                            q_cmd.image_width = hw;
                            q_cmd.image_height = hh;
                            map_length_next = hlen[tgaisp_pkg::MAP_LEN_W-1:0];
                            id_left_next = header_reg[0];
                            map_index_next = '0;
                            triple_pos_next = '0;
                            triple_next = '0;
                            if (header_reg[0] != 8'd0)
                                phase_next = tgaisp_pkg::PH_ID;
                            else if (hlen == 16'd0)
                            begin
                                q_cmd.fill_after = 1'b1;
                                column_next = '0;
                                row_next = '0;
                                phase_next = tgaisp_pkg::PH_PIXELS;
                            end
                            else
                                phase_next = tgaisp_pkg::PH_MAP;
                        end
                    end
                end
                tgaisp_pkg::PH_ID:
                begin
                    id_left_next = id_left_reg - 8'd1;
                    if (id_left_next == 8'd0)
                    begin
                        map_index_next = '0;
                        triple_pos_next = '0;
                        triple_next = '0;
                        if (map_length_reg == '0)
                        begin
                            q_push = 1'b1;
                            q_cmd.kind = tgaisp_pkg::KIND_FILL;
                            column_next = '0;
                            row_next = '0;
                            phase_next = tgaisp_pkg::PH_PIXELS;
                        end
                        else
                            phase_next = tgaisp_pkg::PH_MAP;
                    end
                end
                tgaisp_pkg::PH_MAP:
                begin
                    if (triple_pos_reg != 2'd2)
                    begin
                        if (triple_pos_reg == 2'd0)
                            triple_next[7:0] = data_byte;
                        else
                            triple_next[15:8] = data_byte;
                        triple_pos_next = triple_pos_reg + 2'd1;
                    end
                    else
                    begin
                        q_push = 1'b1;
                        q_cmd.kind = tgaisp_pkg::KIND_PALETTE;
                        q_cmd.entry_or_x = 16'(map_index_reg);
                        q_cmd.value_or_red = data_byte;
                        q_cmd.green = triple_reg[15:8];
                        q_cmd.blue = triple_reg[7:0];
                        triple_pos_next = '0;
                        triple_next = '0;
                        map_index_next = idx_inc;
                        if (idx_inc == map_length_reg)
                        begin
                            q_cmd.fill_after =
                                (16'(map_length_reg) < 16'(tgaisp_pkg::PALETTE_ENTRIES));
                            q_cmd.fill_start = map_length_reg;
                            column_next = '0;
                            row_next = '0;
                            phase_next = tgaisp_pkg::PH_PIXELS;
                        end
                    end
                end
                tgaisp_pkg::PH_PIXELS:
                begin
                    q_push = 1'b1;
                    q_cmd.kind = tgaisp_pkg::KIND_PIXEL;
                    q_cmd.entry_or_x = column_reg;
                    q_cmd.pixel_row = ((header_reg[17] & tgaisp_pkg::TGA_TOP_ORIGIN) != 8'd0)
                        ? row_reg : (ph_h - 16'd1 - row_reg);
                    q_cmd.value_or_red = data_byte;
                    column_next = column_reg + 16'd1;
                    if (column_next == pw)
                    begin
                        column_next = '0;
                        row_next = row_reg + 16'd1;
                        if (row_next == ph_h)
                            phase_next = tgaisp_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tgaisp_pkg::PH_HEADER;
            byte_count_reg <= '0;
            id_left_reg <= '0;
            map_length_reg <= '0;
            map_index_reg <= '0;
            triple_reg <= '0;
            triple_pos_reg <= '0;
            column_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < tgaisp_pkg::HDR_BYTES; i++)
                header_reg[i] <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            byte_count_reg <= byte_count_next;
            id_left_reg <= id_left_next;
            map_length_reg <= map_length_next;
            map_index_reg <= map_index_next;
            triple_reg <= triple_next;
            triple_pos_reg <= triple_pos_next;
            column_reg <= column_next;
            row_reg <= row_next;
            if (accept && ph == tgaisp_pkg::PH_HEADER)
                header_reg[bc] <= data_byte;
        end
    end

endmodule

>>> sv/tgaisp_cmd_fifo.sv
// Short command queue between the front end and the result stage.
module tgaisp_cmd_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tgaisp_pkg::cmd_t push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output tgaisp_pkg::cmd_t head_cmd
);

    tgaisp_pkg::cmd_t                  slot_reg [tgaisp_pkg::QUEUE_DEPTH];
    logic [tgaisp_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [tgaisp_pkg::QPTR_W:0]       count_reg, count_next;
    logic                              do_push, do_pop;

    assign full = (count_reg == (tgaisp_pkg::QPTR_W+1)'(tgaisp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

endmodule

>>> sv/tgaisp_back.sv
// Result stage: expands queued commands into result requests on the output register.
module tgaisp_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_not_empty,
    input  tgaisp_pkg::cmd_t                 q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output tgaisp_pkg::cmd_t                 res,
    output logic                             res_last
);

    logic                                 valid_reg, valid_next;
    tgaisp_pkg::cmd_t                     res_reg, res_next;
    logic                                 last_reg, last_next;
    logic                                 pend_reg, pend_next;
    logic [tgaisp_pkg::MAP_LEN_W-1:0]     pend_start_reg, pend_start_next;
    logic                                 can_load;

    assign can_load = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res = res_reg;
    assign res_last = last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        res_next = res_reg;
        last_next = last_reg;
        pend_next = pend_reg;
        pend_start_next = pend_start_reg;
        q_pop = 1'b0;
        if (can_load)
        begin
            if (pend_reg)
            begin
                res_next = '0;
                res_next.kind = tgaisp_pkg::KIND_FILL;
                res_next.entry_or_x = 16'(pend_start_reg);
                last_next = 1'b1;
                valid_next = 1'b1;
                pend_next = 1'b0;
            end
            else if (q_not_empty)
            begin
                q_pop = 1'b1;
                res_next = q_head;
                last_next = !q_head.fill_after;
                valid_next = 1'b1;
                pend_next = q_head.fill_after;
                pend_start_next = q_head.fill_start;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        last_reg <= last_next;
        pend_start_reg <= pend_start_next;
    end

endmodule

>>> sv/tga_indexed_stream_parser.sv
// Top level of the color-mapped 8-bit TGA stream parser.
// The parser takes one file byte per cycle. Each byte is classified in the
// front end in the cycle it is accepted, and any request it causes enters a
// four-entry command queue. The result stage issues one request per cycle while
// out_ready is high, so a byte that causes two requests (a header with no ID
// field and no map, or the last palette entry of a short map) has them issued one
// after the other; the queue absorbs these while input continues at one byte per
// cycle, and input stalls only when the queue is full.
module tga_indexed_stream_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [2:0]  error_code,
    output logic [15:0] entry_or_x,
    output logic [15:0] pixel_row,
    output logic [7:0]  value_or_red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic        last
);

    logic             q_full, q_push, q_pop, q_not_empty;
    tgaisp_pkg::cmd_t q_cmd, q_head, res;

    tgaisp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .start_file(start_file),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    tgaisp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_cmd (q_head)
    );

    tgaisp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_not_empty(q_not_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res        (res),
        .res_last   (last)
    );

    assign kind = res.kind;
    assign error_code = res.error_code;
    assign entry_or_x = res.entry_or_x;
    assign pixel_row = res.pixel_row;
    assign value_or_red = res.value_or_red;
    assign green = res.green;
    assign blue = res.blue;
    assign image_width = res.image_width;
    assign image_height = res.image_height;

    a_fill_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == tgaisp_pkg::KIND_FILL |-> last)
        else $error("Fill request without last flag.");

    a_code_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != tgaisp_pkg::KIND_ERROR |-> error_code == tgaisp_pkg::ERR_NONE)
        else $error("Error code on a request that is not an error.");

    a_fill_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last &&
        (kind == tgaisp_pkg::KIND_HEADER || kind == tgaisp_pkg::KIND_PALETTE)
        |=> out_valid && kind == tgaisp_pkg::KIND_FILL)
        else $error("Fill request did not follow its first request.");

endmodule
